[design/sds_pkg.sv]
`timescale 1ns / 1ps
package sds_pkg;

    localparam int ST_W       = 20;
    localparam int MS_W       = 31;
    localparam int CFG_DATA_W = 31;

    localparam logic [ST_W-1:0] ST_RESET        = 20'd19661;
    localparam logic [MS_W-1:0] MS_RESET        = 31'h7FFF_FFFF;
    localparam logic [MS_W-1:0] SPEED_UNLIMITED = 31'h7FFF_FFFF;

    typedef enum logic [0:0] {
        CFG_SMOOTH_TIME = 1'b0,
        CFG_MAX_SPEED   = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0] current_value;
        logic signed [31:0] target_value;
        logic signed [31:0] velocity_in;
        logic        [17:0] delta_time;
    } t_item;

    typedef struct packed {
        logic signed [31:0] value_out;
        logic signed [31:0] velocity_out;
    } t_result;

endpackage

[design/smooth_damp_step.sv]
// Path: input stages, omega divider, exponent stages, decay divider, output stages.
// Throughput: one transaction per cycle; busy stays low, start is always taken.
// The two bit-per-stage dividers set the depth; each multiply takes two stages.
// The receiver cannot stall: o_valid strobes for one cycle per transaction.
// Synchronous reset clears all valid bits and restores both registers.
`timescale 1ns / 1ps
module smooth_damp_step #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  sds_pkg::t_item                i_item,
    input  logic                          i_cfg_we,
    input  sds_pkg::t_cfg_idx             i_cfg_idx,
    input  logic [sds_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                          o_valid,
    output sds_pkg::t_result              o_result
);

    localparam int W    = DATA_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int XW   = ((W > 32) ? W : 32) + 2;
    localparam int PW   = 2 * W;
    localparam int RW   = PW - F;
    localparam int H    = (W + 1) / 2;
    localparam int HI   = W - H;
    localparam int NUM1 = 2 * F + 2;
    localparam int NUM2 = ((2 * F + 1 > W - 1) ? (2 * F + 1) : (W - 1)) + 1;
    localparam int CW1  = NUM1 + W;
    localparam int LAT  = 18 + NUM1 + NUM2;

    localparam int    MIN_ST_R = ((1 << F) + 5000) / 10000;
    localparam int    MIN_ST   = (MIN_ST_R < 1) ? 1 : MIN_ST_R;
    localparam longint K48_L   = ((longint'(48) << F) + 50) / 100;
    localparam longint K235_L  = ((longint'(235) << F) + 500) / 1000;

    localparam logic signed [W-1:0]  VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]  VMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0]  ONE  = W'(longint'(1) << F);
    localparam logic signed [W-1:0]  K48  = W'(K48_L);
    localparam logic signed [W-1:0]  K235 = W'(K235_L);
    localparam logic [PW-1:0]        HALF = PW'(1) << (F - 1);
    localparam logic signed [31:0]   I32MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0]   I32MIN = 32'sh8000_0000;
    localparam logic [NUM1-1:0]      NUM1_BASE = NUM1'(1) << (2 * F + 1);
    localparam logic [NUM2-1:0]      NUM2_BASE = NUM2'(1) << (2 * F);
    localparam logic [sds_pkg::ST_W-1:0] MIN_ST_V = sds_pkg::ST_W'(MIN_ST);

    typedef struct packed {
        logic          neg;
        logic [2*H-1:0]  ll;
        logic [W-1:0]    lh;
        logic [W-1:0]    hl;
        logic [2*HI-1:0] hh;
    } t_pp;

    typedef struct packed {
        logic signed [W-1:0] cur;
        logic signed [W-1:0] tgt0;
        logic signed [W-1:0] vel;
        logic signed [W-1:0] dt;
        logic signed [W-1:0] st;
        logic signed [W-1:0] ms;
        logic                unlim;
        logic signed [W-1:0] change;
        logic signed [W-1:0] mc;
        logic signed [W-1:0] tgt;
        logic signed [W-1:0] omega;
        logic signed [W-1:0] x;
        logic signed [W-1:0] oc;
        logic signed [W-1:0] x2;
        logic signed [W-1:0] va;
        logic signed [W-1:0] temp;
        logic signed [W-1:0] x3;
        logic signed [W-1:0] t48;
        logic signed [W-1:0] ot;
        logic signed [W-1:0] t235;
        logic signed [W-1:0] den;
        logic signed [W-1:0] nv;
        logic signed [W-1:0] ct;
        logic signed [W-1:0] nvel;
        logic signed [W-1:0] pe;
        logic signed [W-1:0] outv;
        t_pp                 pa;
        t_pp                 pb;
    } t_ctx;

    localparam int CTX_W = $bits(t_ctx);

    function automatic logic signed [W-1:0] sat(input logic signed [XW-1:0] v);
        logic signed [W-1:0] res;
        if (v > XW'(VMAX)) begin
            res = VMAX;
        end else if (v < XW'(VMIN)) begin
            res = VMIN;
        end else begin
            res = v[W-1:0];
        end
        return res;
    endfunction

    function automatic logic signed [31:0] to32(input logic signed [W-1:0] v);
        logic signed [XW-1:0] xv;
        logic signed [31:0]   res;
        xv = XW'(v);
        if (xv > XW'(I32MAX)) begin
            res = I32MAX;
        end else if (xv < XW'(I32MIN)) begin
            res = I32MIN;
        end else begin
            res = xv[31:0];
        end
        return res;
    endfunction

    function automatic t_pp mul_pp(input logic signed [W-1:0] a,
                                   input logic signed [W-1:0] b);
        logic [W-1:0] ua;
        logic [W-1:0] ub;
        t_pp          p;
        ua    = a[W-1] ? W'(~a + 1'b1) : W'(a);
        ub    = b[W-1] ? W'(~b + 1'b1) : W'(b);
        p.neg = a[W-1] ^ b[W-1];
        p.ll  = ua[H-1:0] * ub[H-1:0];
        p.lh  = ua[H-1:0] * ub[W-1:H];
        p.hl  = ua[W-1:H] * ub[H-1:0];
        p.hh  = ua[W-1:H] * ub[W-1:H];
        return p;
    endfunction

    function automatic logic signed [W-1:0] mul_fin(input t_pp p);
        logic [PW-1:0]       full;
        logic [RW-1:0]       r;
        logic signed [W-1:0] res;
        full = PW'(p.ll) + (PW'(p.lh) << H) + (PW'(p.hl) << H)
             + (PW'(p.hh) << (2 * H)) + HALF;
        r    = full[PW-1:F];
        if (r > RW'(VMAX)) begin
            res = p.neg ? VMIN : VMAX;
        end else if (p.neg) begin
            res = W'(~r[W-1:0] + 1'b1);
        end else begin
            res = r[W-1:0];
        end
        return res;
    endfunction

    logic [sds_pkg::ST_W-1:0] r_smooth_time;
    logic [sds_pkg::MS_W-1:0] r_max_speed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth_time <= sds_pkg::ST_RESET;
            r_max_speed   <= sds_pkg::MS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sds_pkg::CFG_SMOOTH_TIME: r_smooth_time <= i_cfg_data[sds_pkg::ST_W-1:0];
                sds_pkg::CFG_MAX_SPEED:   r_max_speed   <= i_cfg_data[sds_pkg::MS_W-1:0];
                default: ;
            endcase
        end
    end

    t_ctx r_a [4];
    t_ctx n_a [4];
    logic r_av [4];
    t_ctx r_e [10];
    t_ctx n_e [10];
    logic r_ev [10];
    t_ctx r_g [3];
    t_ctx n_g [3];
    logic r_gv [3];

    logic                   d1_vld;
    logic [NUM1-1:0]        d1_quot;
    logic [CTX_W-1:0]       d1_pay;
    logic [NUM1-1:0]        d1_num;
    logic                   d2_vld;
    logic [NUM2-1:0]        d2_quot;
    logic [CTX_W-1:0]       d2_pay;
    logic [NUM2-1:0]        d2_num;
    logic signed [W-1:0]    expo;
    logic                   snap;
    sds_pkg::t_result       n_result;
    sds_pkg::t_result       r_result;
    logic                   r_out_vld;

    assign busy = 1'b0;

    always_comb begin
        logic signed [W-1:0]         ch;
        logic [sds_pkg::ST_W-1:0]    stf;
        ch  = '0;
        stf = (r_smooth_time < MIN_ST_V) ? MIN_ST_V : r_smooth_time;

        n_a[0]        = '0;
        n_a[0].cur    = sat(XW'($signed(i_item.current_value)));
        n_a[0].tgt0   = sat(XW'($signed(i_item.target_value)));
        n_a[0].vel    = sat(XW'($signed(i_item.velocity_in)));
        n_a[0].dt     = $signed(W'(i_item.delta_time));
        n_a[0].st     = $signed(W'(stf));
        n_a[0].ms     = sat(XW'($signed({1'b0, r_max_speed})));
        n_a[0].unlim  = (r_max_speed == sds_pkg::SPEED_UNLIMITED);

        n_a[1]        = r_a[0];
        n_a[1].change = sat(XW'(r_a[0].cur) - XW'(r_a[0].tgt0));
        n_a[1].pa     = mul_pp(r_a[0].ms, r_a[0].st);

        n_a[2]        = r_a[1];
        n_a[2].mc     = mul_fin(r_a[1].pa);

        n_a[3]        = r_a[2];
        ch            = r_a[2].change;
        if (!r_a[2].unlim) begin
            priority if (ch > r_a[2].mc) begin
                ch = r_a[2].mc;
            end else if (ch < -r_a[2].mc) begin
                ch = -r_a[2].mc;
            end
        end
        n_a[3].change = ch;
        n_a[3].tgt    = sat(XW'(r_a[2].cur) - XW'(ch));
    end

    assign d1_num = NUM1_BASE + NUM1'(r_a[3].st[sds_pkg::ST_W-1:1]);

    sds_div #(
        .NUM_W (NUM1),
        .DEN_W (sds_pkg::ST_W),
        .PAY_W (CTX_W)
    ) u_div_omega (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_av[3]),
        .i_num   (d1_num),
        .i_den   (r_a[3].st[sds_pkg::ST_W-1:0]),
        .i_pay   (r_a[3]),
        .o_valid (d1_vld),
        .o_quot  (d1_quot),
        .o_pay   (d1_pay)
    );

    always_comb begin
        n_e[0]       = t_ctx'(d1_pay);
        n_e[0].omega = (CW1'(d1_quot) > CW1'(VMAX)) ? VMAX : W'(d1_quot);

        n_e[1]       = r_e[0];
        n_e[1].pa    = mul_pp(r_e[0].omega, r_e[0].dt);
        n_e[1].pb    = mul_pp(r_e[0].omega, r_e[0].change);

        n_e[2]       = r_e[1];
        n_e[2].x     = mul_fin(r_e[1].pa);
        n_e[2].oc    = mul_fin(r_e[1].pb);

        n_e[3]       = r_e[2];
        n_e[3].pa    = mul_pp(r_e[2].x, r_e[2].x);
        n_e[3].va    = sat(XW'(r_e[2].vel) + XW'(r_e[2].oc));

        n_e[4]       = r_e[3];
        n_e[4].x2    = mul_fin(r_e[3].pa);
        n_e[4].pb    = mul_pp(r_e[3].va, r_e[3].dt);

        n_e[5]       = r_e[4];
        n_e[5].pa    = mul_pp(r_e[4].x2, r_e[4].x);
        n_e[5].pb    = mul_pp(K48, r_e[4].x2);
        n_e[5].temp  = mul_fin(r_e[4].pb);
        n_e[5].den   = sat(XW'(ONE) + XW'(r_e[4].x));

        n_e[6]       = r_e[5];
        n_e[6].x3    = mul_fin(r_e[5].pa);
        n_e[6].t48   = mul_fin(r_e[5].pb);
        n_e[6].pa    = mul_pp(r_e[5].omega, r_e[5].temp);

        n_e[7]       = r_e[6];
        n_e[7].ot    = mul_fin(r_e[6].pa);
        n_e[7].pb    = mul_pp(K235, r_e[6].x3);
        n_e[7].den   = sat(XW'(r_e[6].den) + XW'(r_e[6].t48));
        n_e[7].ct    = sat(XW'(r_e[6].change) + XW'(r_e[6].temp));

        n_e[8]       = r_e[7];
        n_e[8].t235  = mul_fin(r_e[7].pb);
        n_e[8].nv    = sat(XW'(r_e[7].vel) - XW'(r_e[7].ot));

        n_e[9]       = r_e[8];
        n_e[9].den   = sat(XW'(r_e[8].den) + XW'(r_e[8].t235));
    end

    assign d2_num = NUM2_BASE + NUM2'(r_e[9].den[W-1:1]);

    sds_div #(
        .NUM_W (NUM2),
        .DEN_W (W - 1),
        .PAY_W (CTX_W)
    ) u_div_expo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_ev[9]),
        .i_num   (d2_num),
        .i_den   (r_e[9].den[W-2:0]),
        .i_pay   (r_e[9]),
        .o_valid (d2_vld),
        .o_quot  (d2_quot),
        .o_pay   (d2_pay)
    );

    assign expo = $signed(d2_quot[W-1:0]);

    always_comb begin
        n_g[0]      = t_ctx'(d2_pay);
        n_g[0].pa   = mul_pp(n_g[0].nv, expo);
        n_g[0].pb   = mul_pp(n_g[0].ct, expo);

        n_g[1]      = r_g[0];
        n_g[1].nvel = mul_fin(r_g[0].pa);
        n_g[1].pe   = mul_fin(r_g[0].pb);

        n_g[2]      = r_g[1];
        n_g[2].outv = sat(XW'(r_g[1].tgt) + XW'(r_g[1].pe));

        snap = ((r_g[2].tgt0 > r_g[2].cur) == (r_g[2].outv > r_g[2].tgt0));
        n_result.value_out    = snap ? to32(r_g[2].tgt0) : to32(r_g[2].outv);
        n_result.velocity_out = snap ? 32'sd0 : to32(r_g[2].nvel);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) r_av[k] <= 1'b0;
            for (int k = 0; k < 10; k++) r_ev[k] <= 1'b0;
            for (int k = 0; k < 3; k++) r_gv[k] <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_av[0] <= start && !busy;
            for (int k = 1; k < 4; k++) r_av[k] <= r_av[k-1];
            r_ev[0] <= d1_vld;
            for (int k = 1; k < 10; k++) r_ev[k] <= r_ev[k-1];
            r_gv[0] <= d2_vld;
            for (int k = 1; k < 3; k++) r_gv[k] <= r_gv[k-1];
            r_out_vld <= r_gv[2];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) r_a[k] <= n_a[k];
        for (int k = 0; k < 10; k++) r_e[k] <= n_e[k];
        for (int k = 0; k < 3; k++) r_g[k] <= n_g[k];
        r_result <= n_result;
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_result;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("transaction result missing after pipeline latency");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result strobe without matching transaction");

    a_omega_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        d1_vld |-> (d1_quot != '0))
        else $error("omega quotient is zero");

    a_expo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        d2_vld |-> (d2_quot <= (NUM2'(1) << F)))
        else $error("decay factor above one");

    a_snap_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_gv[2] && snap) |=> (o_result.velocity_out == 32'sd0))
        else $error("snapped result carries nonzero velocity");

endmodule

[design/sds_div.sv]
`timescale 1ns / 1ps
module sds_div #(
    parameter int NUM_W = 34,
    parameter int DEN_W = 20,
    parameter int PAY_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [PAY_W-1:0] i_pay,
    output logic             o_valid,
    output logic [NUM_W-1:0] o_quot,
    output logic [PAY_W-1:0] o_pay
);

    logic             r_vld [NUM_W];
    logic [NUM_W-1:0] r_q   [NUM_W];
    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];
    logic [PAY_W-1:0] r_pay [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic             p_vld;
        logic [NUM_W-1:0] p_q;
        logic [DEN_W-1:0] p_rem;
        logic [DEN_W-1:0] p_den;
        logic [PAY_W-1:0] p_pay;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             qbit;
        logic [DEN_W-1:0] n_rem;
        logic [NUM_W-1:0] n_q;

        if (k == 0) begin : g_first
            assign p_vld = i_valid;
            assign p_q   = i_num;
            assign p_rem = '0;
            assign p_den = i_den;
            assign p_pay = i_pay;
        end else begin : g_next
            assign p_vld = r_vld[k-1];
            assign p_q   = r_q[k-1];
            assign p_rem = r_rem[k-1];
            assign p_den = r_den[k-1];
            assign p_pay = r_pay[k-1];
        end

        always_comb begin
            trial = {p_rem, p_q[NUM_W-1]};
            diff  = trial - {1'b0, p_den};
            qbit  = (trial >= {1'b0, p_den});
            n_rem = qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            n_q   = {p_q[NUM_W-2:0], qbit};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_q[k]   <= n_q;
            r_rem[k] <= n_rem;
            r_den[k] <= p_den;
            r_pay[k] <= p_pay;
        end
    end

    assign o_valid = r_vld[NUM_W-1];
    assign o_quot  = r_q[NUM_W-1];
    assign o_pay   = r_pay[NUM_W-1];

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
module testbench;

    localparam int LATENCY = 86;
    localparam longint VMAX = 64'sd2147483647;
    localparam longint VMIN = -64'sd2147483648;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           start;
    logic                           busy;
    sds_pkg::t_item                 i_item;
    logic                           i_cfg_we;
    sds_pkg::t_cfg_idx              i_cfg_idx;
    logic [sds_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                           o_valid;
    sds_pkg::t_result               o_result;

    smooth_damp_step u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

    sds_pkg::t_item   pending_items[$];
    sds_pkg::t_result expected_steps[$];
    logic [sds_pkg::ST_W-1:0] model_smooth_time;
    logic [sds_pkg::MS_W-1:0] model_max_speed;
    int  error_count = 0;
    bit  drain_hold;
    int  gap_left;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic longint clamp_q(longint v);
        if (v > VMAX) return VMAX;
        if (v < VMIN) return VMIN;
        return v;
    endfunction

    // round half away from zero, saturate
    function automatic longint fx_mul(longint a, longint b);
        logic signed [127:0] p;
        logic [127:0]        m;
        bit                  neg;
        p = 128'(signed'(a)) * 128'(signed'(b));
        neg = p < 0;
        m = neg ? -p : p;
        m = (m + 128'd32768) >> 16;
        if (neg) begin
            if (m > 128'd2147483648) return VMIN;
            return -longint'(m);
        end
        if (m > 128'd2147483647) return VMAX;
        return longint'(m);
    endfunction

    function automatic longint fx_div(longint num, longint den);
        longint q;
        q = (num + den / 2) / den;
        return q > VMAX ? VMAX : q;
    endfunction

    function automatic sds_pkg::t_result damp_step(sds_pkg::t_item it);
        longint cur, tgt0, vel, dt, st, omega, x, x2, x3, den, expo;
        longint change, tgt, temp, nvel, outv, mc;
        sds_pkg::t_result r;
        cur  = it.current_value;
        tgt0 = it.target_value;
        vel  = it.velocity_in;
        dt   = longint'(it.delta_time);
        st   = longint'(model_smooth_time);
        if (st < 7) st = 7;
        omega = fx_div(64'd1 << 33, st);
        x  = fx_mul(omega, dt);
        x2 = fx_mul(x, x);
        x3 = fx_mul(x2, x);
        den = clamp_q(65536 + x);
        den = clamp_q(den + fx_mul(31457, x2));
        den = clamp_q(den + fx_mul(15401, x3));
        expo = fx_div(64'd1 << 32, den);
        change = clamp_q(cur - tgt0);
        if (model_max_speed != sds_pkg::SPEED_UNLIMITED) begin
            mc = fx_mul(longint'(model_max_speed), st);
            if (change > mc) change = mc;
            if (change < -mc) change = -mc;
        end
        tgt  = clamp_q(cur - change);
        temp = fx_mul(clamp_q(vel + fx_mul(omega, change)), dt);
        nvel = fx_mul(clamp_q(vel - fx_mul(omega, temp)), expo);
        outv = clamp_q(tgt + fx_mul(clamp_q(change + temp), expo));
        if ((tgt0 > cur) == (outv > tgt0)) begin
            outv = tgt0;
            nvel = 0;
        end
        r.value_out    = outv[31:0];
        r.velocity_out = nvel[31:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
            3: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic sds_pkg::t_item rand_item();
        sds_pkg::t_item it;
        it.current_value = rand_word();
        it.target_value  = ($urandom_range(0, 3) == 0) ? it.current_value : rand_word();
        it.velocity_in   = rand_word();
        case ($urandom_range(0, 4))
            0: it.delta_time = 18'd0;
            1: it.delta_time = 18'h3FFFF;
            2: it.delta_time = 18'($urandom_range(0, 4000));
            default: it.delta_time = 18'($urandom);
        endcase
        return it;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n || drain_hold) begin
            start <= 1'b0;
        end else if (start && busy) begin
            start <= 1'b1;
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start    <= 1'b0;
        end else if (pending_items.size() > 0) begin
            i_item <= pending_items.pop_front();
            start  <= 1'b1;
            gap_left <= pick_gap();
        end else begin
            start <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) expected_steps.push_back(damp_step(i_item));
    end

    // monitor
    always @(posedge i_clk) begin
        sds_pkg::t_result want;
        if (i_rst_n && o_valid) begin
            if (expected_steps.size() == 0) begin
                report_mismatch("unexpected transaction", o_result.value_out, 0);
            end else begin
                want = expected_steps.pop_front();
                if (o_result.value_out !== want.value_out)
                    report_mismatch("value_out", o_result.value_out, want.value_out);
                if (o_result.velocity_out !== want.velocity_out)
                    report_mismatch("velocity_out", o_result.velocity_out, want.velocity_out);
            end
        end
    end

    task automatic wait_idle();
        while (pending_items.size() > 0 || start)
            @(negedge i_clk);
        drain_hold = 1'b1;
        while (expected_steps.size() > 0)
            @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic write_reg(sds_pkg::t_cfg_idx idx, logic [sds_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == sds_pkg::CFG_SMOOTH_TIME) model_smooth_time = val[sds_pkg::ST_W-1:0];
        else model_max_speed = val[sds_pkg::MS_W-1:0];
    endtask

    task automatic run_batch(int count);
        repeat (count) pending_items.push_back(rand_item());
        drain_hold = 1'b0;
        wait_idle();
    endtask

    initial begin
        sds_pkg::t_item it;
        logic [31:0] edges[4];
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = sds_pkg::CFG_SMOOTH_TIME;
        i_cfg_data = '0;
        drain_hold = 1'b1;
        model_smooth_time = sds_pkg::ST_RESET;
        model_max_speed   = sds_pkg::MS_RESET;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        edges = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};
        foreach (edges[a]) begin
            foreach (edges[b]) begin
                it.current_value = edges[a];
                it.target_value  = edges[b];
                it.velocity_in   = edges[(a + b) % 4];
                it.delta_time    = (a + b) % 2 ? 18'h3FFFF : 18'd0;
                pending_items.push_back(it);
            end
        end
        it = '{32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 18'd1092};
        pending_items.push_back(it);
        it = '{32'h0000_0000, 32'h000A_0000, 32'h0005_0000, 18'd1092};
        pending_items.push_back(it);
        drain_hold = 1'b0;
        wait_idle();

        run_batch(300);
        write_reg(sds_pkg::CFG_SMOOTH_TIME, 31'd0);
        write_reg(sds_pkg::CFG_MAX_SPEED, 31'd0);
        run_batch(150);
        write_reg(sds_pkg::CFG_SMOOTH_TIME, 31'd655360);
        write_reg(sds_pkg::CFG_MAX_SPEED, 31'h0001_0000);
        run_batch(250);
        write_reg(sds_pkg::CFG_SMOOTH_TIME, 31'hFFFFF);
        write_reg(sds_pkg::CFG_MAX_SPEED, 31'h7FFF_FFFE);
        run_batch(200);
        write_reg(sds_pkg::CFG_SMOOTH_TIME, 31'd7);
        write_reg(sds_pkg::CFG_MAX_SPEED, 31'h7FFF_FFFF);
        run_batch(200);
        repeat (8) begin
            write_reg(sds_pkg::CFG_SMOOTH_TIME, 31'($urandom_range(0, 20'hFFFFF)));
            write_reg(sds_pkg::CFG_MAX_SPEED, 31'($urandom));
            run_batch(50);
        end

        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("testbench: errors");
        $finish;
    end

endmodule
